// File: src/zlhs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package zlhs_pkg;

    // scanner phase
    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2
    } t_phase;

    // terminator kind carried with each record
    localparam logic [1:0] END_LOCAL   = 2'd0;
    localparam logic [1:0] END_CENTRAL = 2'd1;
    localparam logic [1:0] END_STREAM  = 2'd2;

    localparam logic [31:0] SIG_LOCAL   = 32'h504B_0304;
    localparam logic [31:0] SIG_CENTRAL = 32'h504B_0102;

    // fixed local header length, and bytes of a signature after its first
    localparam int HDR_LEN  = 30;
    localparam int SIG_TAIL = 3;

    // header-relative offsets of the two length fields
    localparam logic [4:0] REL_NAME_LO  = 5'd26;
    localparam logic [4:0] REL_NAME_HI  = 5'd27;
    localparam logic [4:0] REL_EXTRA_LO = 5'd28;
    localparam logic [4:0] REL_EXTRA_HI = 5'd29;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_word;

    typedef struct packed {
        logic [15:0] entry_index;
        logic [31:0] header_offset;
        logic [15:0] name_length;
        logic [15:0] extra_length;
        logic [31:0] data_offset;
        logic [31:0] data_size;
        logic [1:0]  ended_by;
    } t_rec;

endpackage

`default_nettype wire

// File: src/zip_local_header_scanner_core.sv
// Path: the word that completes a record goes through the input register, then the
//   scan logic into the result register, which waits while the output is held.
// Throughput: one archive byte per cycle while the result register has room to load.
// Reset: i_rst_n synchronous, active low; clears both stages and all scan state.
// A word with tlast set returns the scanner to offset 0 for the next archive.
`timescale 1ns / 1ps
`default_nettype none

module zip_local_header_scanner_core #(
    parameter int OFFSET_WIDTH = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // archive bytes in
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire logic         s_axis_tlast,   // end_of_stream
    // one record per entry out
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [15:0] entry_index, [47:16] header_offset, [63:48] name_length,
    // [79:64] extra_length, [111:80] data_offset, [143:112] data_size
    output logic [143:0]      m_axis_tdata,
    output logic [1:0]        m_axis_tuser    // [1:0] ended_by
);
    import zlhs_pkg::*;

    t_in_word s_word;
    t_in_word in_word;
    logic     in_valid;
    logic     out_can_load;
    logic     step;
    logic     rec_valid;
    t_rec     rec;
    t_rec     out_rec;

    assign s_word.data_byte     = s_axis_tdata;
    assign s_word.end_of_stream = s_axis_tlast;

    // a held word is scanned as soon as the result register has room,
    // whether or not it completes a record
    assign step = in_valid && out_can_load;

    zlhs_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_word  (s_word),
        .o_valid (in_valid),
        .o_word  (in_word),
        .i_take  (step)
    );

    zlhs_parse #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_word      (in_word),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    zlhs_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (rec_valid),
        .i_rec       (rec),
        .o_can_load  (out_can_load),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_rec       (out_rec)
    );

    assign m_axis_tdata = {out_rec.data_size, out_rec.data_offset, out_rec.extra_length,
                           out_rec.name_length, out_rec.header_offset,
                           out_rec.entry_index};
    assign m_axis_tuser = out_rec.ended_by;

endmodule

`default_nettype wire

// File: src/zlhs_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module zlhs_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire zlhs_pkg::t_in_word i_word,
    output logic                   o_valid,
    output zlhs_pkg::t_in_word     o_word,
    input  wire logic              i_take
);
    import zlhs_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    // refill in the same cycle the held word is consumed
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

// File: src/zlhs_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module zlhs_parse #(
    parameter int OFFSET_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire zlhs_pkg::t_in_word i_word,
    output logic                    o_rec_valid,
    output zlhs_pkg::t_rec          o_rec
);
    import zlhs_pkg::*;

    localparam int W = OFFSET_WIDTH;
    localparam logic [W-1:0] OFF_MAX = '1;

    logic [23:0]  r_recent, n_recent;
    logic [W-1:0] r_pos,    n_pos;
    t_phase       r_phase,  n_phase;
    logic [W-1:0] r_hdr,    n_hdr;
    logic [W-1:0] r_base,   n_base;   // saturated header start + 30
    logic [15:0]  r_name,   n_name;
    logic [15:0]  r_extra,  n_extra;
    logic [W-1:0] r_ds,     n_ds;
    logic [15:0]  r_cnt,    n_cnt;
    logic [4:0]   r_rel,    n_rel;    // header offset of the next byte

    logic [7:0]   b;
    logic [31:0]  win;
    logic         is_local;
    logic         is_central;
    logic         pos_max;
    logic [W-1:0] pos_next;
    logic [W-1:0] sig_start;
    logic [W:0]   base_sum;
    logic [W-1:0] base_sat;
    logic [4:0]   rel_init;
    logic [15:0]  extra_new;
    logic [16:0]  len_sum;
    logic [W+1:0] ds_sum;
    logic [W-1:0] ds_new;
    logic [W:0]   term_diff;
    logic         term_ok;
    logic [W:0]   end_diff;

    logic         emit;
    logic [1:0]   emit_kind;
    logic [W-1:0] emit_size;
    logic [W+31:0] ext_hdr;
    logic [W+31:0] ext_ds;
    logic [W+31:0] ext_size;

    assign b          = i_word.data_byte;
    assign win        = {r_recent, b};
    assign is_local   = (win == SIG_LOCAL);
    assign is_central = (win == SIG_CENTRAL);
    assign pos_max    = (r_pos == OFF_MAX);
    assign pos_next   = pos_max ? r_pos : r_pos + W'(1);
    assign sig_start  = r_pos - W'(SIG_TAIL);

    // header start + 30 == position + 27
    assign base_sum = {1'b0, r_pos} + (W+1)'(HDR_LEN - SIG_TAIL);
    assign base_sat = base_sum[W] ? OFF_MAX : base_sum[W-1:0];
    assign rel_init = 5'(SIG_TAIL) + {4'b0, !pos_max};

    assign extra_new = {b, r_extra[7:0]};
    assign len_sum   = {1'b0, r_name} + {1'b0, extra_new};
    assign ds_sum    = {2'b0, r_base} + (W+2)'(len_sum);
    assign ds_new    = (ds_sum[W+1:W] != 2'b00) ? OFF_MAX : ds_sum[W-1:0];

    // borrow out means the signature starts before the data
    assign term_diff = {1'b0, r_pos} - (W+1)'(SIG_TAIL) - {1'b0, r_ds};
    assign term_ok   = !term_diff[W];
    assign end_diff  = {1'b0, pos_next} - {1'b0, r_ds};

    always_comb begin
        n_recent  = r_recent;
        n_pos     = r_pos;
        n_phase   = r_phase;
        n_hdr     = r_hdr;
        n_base    = r_base;
        n_name    = r_name;
        n_extra   = r_extra;
        n_ds      = r_ds;
        n_cnt     = r_cnt;
        n_rel     = r_rel;
        emit      = 1'b0;
        emit_kind = END_LOCAL;
        emit_size = '0;

        if (i_step) begin
            case (r_phase)
                PH_HEADER: begin
                    n_rel = pos_max ? r_rel : r_rel + 5'd1;
                    case (r_rel)
                        REL_NAME_LO:  n_name[7:0]  = b;
                        REL_NAME_HI:  n_name[15:8] = b;
                        REL_EXTRA_LO: n_extra[7:0] = b;
                        REL_EXTRA_HI: begin
                            n_extra = extra_new;
                            n_ds    = ds_new;
                            n_phase = PH_DATA;
                        end
                        default: ;
                    endcase
                end
                PH_DATA: begin
                    if ((is_local || is_central) && term_ok) begin
                        emit      = 1'b1;
                        emit_kind = is_local ? END_LOCAL : END_CENTRAL;
                        emit_size = term_diff[W-1:0];
                        if (is_local) begin
                            n_hdr   = sig_start;
                            n_base  = base_sat;
                            n_rel   = rel_init;
                            n_phase = PH_HEADER;
                        end else begin
                            n_phase = PH_SEARCH;
                        end
                    end
                end
                default: begin
                    // searching; an unused phase code searches too
                    if (is_local) begin
                        n_hdr   = sig_start;
                        n_base  = base_sat;
                        n_rel   = rel_init;
                        n_phase = PH_HEADER;
                    end
                end
            endcase

            if (i_word.end_of_stream) begin
                // data cut by the stream end; on the last header byte the
                // data cannot have begun yet, so its size is zero
                if (n_phase == PH_DATA && !emit) begin
                    emit      = 1'b1;
                    emit_kind = END_STREAM;
                    if (r_phase == PH_DATA && !end_diff[W]) begin
                        emit_size = end_diff[W-1:0];
                    end
                end
            end
        end

        o_rec_valid = emit;
        ext_hdr     = {32'b0, r_hdr};
        ext_ds      = {32'b0, n_ds};
        ext_size    = {32'b0, emit_size};
        o_rec.entry_index   = r_cnt;
        o_rec.header_offset = ext_hdr[31:0];
        o_rec.name_length   = n_name;
        o_rec.extra_length  = n_extra;
        o_rec.data_offset   = ext_ds[31:0];
        o_rec.data_size     = ext_size[31:0];
        o_rec.ended_by      = emit_kind;

        if (emit) begin
            n_cnt = r_cnt + 16'd1;
        end

        if (i_step) begin
            if (i_word.end_of_stream) begin
                n_recent = '0;
                n_pos    = '0;
                n_phase  = PH_SEARCH;
                n_hdr    = '0;
                n_base   = '0;
                n_name   = '0;
                n_extra  = '0;
                n_ds     = '0;
                n_cnt    = '0;
                n_rel    = '0;
            end else begin
                n_recent = win[23:0];
                n_pos    = pos_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent <= '0;
            r_pos    <= '0;
            r_phase  <= PH_SEARCH;
            r_hdr    <= '0;
            r_base   <= '0;
            r_name   <= '0;
            r_extra  <= '0;
            r_ds     <= '0;
            r_cnt    <= '0;
            r_rel    <= '0;
        end else begin
            r_recent <= n_recent;
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_hdr    <= n_hdr;
            r_base   <= n_base;
            r_name   <= n_name;
            r_extra  <= n_extra;
            r_ds     <= n_ds;
            r_cnt    <= n_cnt;
            r_rel    <= n_rel;
        end
    end

    a_rel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_rel >= 5'(SIG_TAIL) && r_rel <= REL_EXTRA_HI))
        else $error("header byte counter out of range");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_word.end_of_stream) |=> (r_pos == '0 && r_phase == PH_SEARCH
                                             && r_cnt == '0))
        else $error("scanner not cleared after final word");

    a_rec_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_valid |-> (r_phase == PH_DATA
                         || (r_phase == PH_HEADER && r_rel == REL_EXTRA_HI
                             && i_word.end_of_stream)))
        else $error("record outside the data phase");

    a_ds_above_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_ds >= r_base))
        else $error("data start below header end");

endmodule

`default_nettype wire

// File: src/zlhs_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module zlhs_out_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_rec_valid,
    input  wire zlhs_pkg::t_rec i_rec,
    output logic                o_can_load,
    output logic                o_valid,
    input  wire logic           i_ready,
    output zlhs_pkg::t_rec      o_rec
);
    import zlhs_pkg::*;

    logic r_valid;
    t_rec r_rec;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_rec      = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_rec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_rec_valid) begin
            r_rec <= i_rec;
        end
    end

endmodule

`default_nettype wire
